/* src/msr_pkg.sv */
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the MIDI scale remapper
// Word layouts, configuration indexes, message types and table entry format.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int NOTE_COUNT    = 128;
    localparam int CHANNEL_COUNT = 16;
    localparam int KEY_W         = 7;
    localparam int CH_W          = 4;
    localparam int ADDR_W        = KEY_W + CH_W;
    localparam int TABLE_DEPTH   = NOTE_COUNT * CHANNEL_COUNT;
    localparam int QUEUE_DEPTH   = 2;
    localparam int TDATA_W       = 24;

    localparam int CFG_DATA_W  = 60;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_OFFSETS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_SHIFT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_ENABLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCED_CHANNEL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUTED_CHANNEL  = 3'd4;

    // C major: white-key classes code 13 (no shift), black-key classes muted
    localparam logic [59:0] CLASS_OFFSETS_RESET = 60'd468832205210137613;

    localparam logic [3:0] MT_NOTE_OFF      = 4'h8;
    localparam logic [3:0] MT_NOTE_ON       = 4'h9;
    localparam logic [3:0] MT_POLY_PRESSURE = 4'hA;

    typedef struct packed {
        logic [59:0]       class_offsets;
        logic signed [6:0] root_shift;
        logic              wrap_enable;
        logic [4:0]        forced_channel;
        logic [4:0]        muted_channel;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_PASS,       // no table access, emit as given
        OP_SET_EMIT,   // write pitch and channel, emit
        OP_SET_QUIET,  // write pitch and channel, no word out
        OP_KEEP_PITCH, // write channel only, emit
        OP_RELEASE     // read entry, restore identity, emit if not dropped
    } t_op;

    // pitch bit 7 marks a dropped note
    typedef struct packed {
        logic [7:0]      pitch;
        logic [CH_W-1:0] chan;
    } t_entry;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        status;
        logic [KEY_W-1:0]  key;
        logic [6:0]        second;
        logic [7:0]        wpitch;
        logic [CH_W-1:0]   wchan;
    } t_item;

endpackage

/* src/msr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// msr_cfg_regs: configuration registers
// Write-only register file; index selects one of five registers.
// ----------------------------------------------------------------------------
module msr_cfg_regs
    import msr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_offsets  <= CLASS_OFFSETS_RESET;
            r_cfg.root_shift     <= 7'sd0;
            r_cfg.wrap_enable    <= 1'b0;
            r_cfg.forced_channel <= 5'd0;
            r_cfg.muted_channel  <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASS_OFFSETS:  r_cfg.class_offsets  <= i_cfg_data[59:0];
                CFG_ROOT_SHIFT:     r_cfg.root_shift     <= $signed(i_cfg_data[6:0]);
                CFG_WRAP_ENABLE:    r_cfg.wrap_enable    <= i_cfg_data[0];
                CFG_FORCED_CHANNEL: r_cfg.forced_channel <= i_cfg_data[4:0];
                CFG_MUTED_CHANNEL:  r_cfg.muted_channel  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/msr_front.sv */
// ----------------------------------------------------------------------------
// msr_front: message classification and note shifting
// Two stages: class lookup and shift sum, then octave fold and queue item.
// ----------------------------------------------------------------------------
module msr_front
    import msr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_hold,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,
    input  logic               i_q_full,
    output logic               o_push,
    output t_item              o_item
);

    typedef enum logic [1:0] {K_PASS, K_ON, K_OFF, K_PRESS} t_kind;

    logic [7:0]       in_st;
    logic [KEY_W-1:0] in_key;
    logic [6:0]       in_sec;
    logic [12:0]      div_prod;
    logic [3:0]       cls_q;
    logic [6:0]       cls_rem;
    logic [3:0]       cls;
    logic [5:0]       code_lo;
    logic [4:0]       code;
    logic signed [8:0] sum;
    t_kind            kind;

    logic             r_f_valid;
    t_kind            r_f_kind;
    logic [7:0]       r_f_st;
    logic [KEY_W-1:0] r_f_key;
    logic [6:0]       r_f_sec;
    logic             r_f_mute;
    logic signed [8:0] r_f_n;

    logic signed [8:0] fold;
    logic             out_of_range;
    logic             drop_shift;
    logic [KEY_W-1:0] np;
    logic [CH_W-1:0]  in_ch;
    logic [CH_W-1:0]  tch;
    logic [CH_W-1:0]  mch;
    logic             mch_none;
    logic             discard;
    logic             f_pop;

    assign in_st  = i_s_axis_tdata[7:0];
    assign in_key = i_s_axis_tdata[14:8];
    assign in_sec = i_s_axis_tdata[21:15];

    // key / 12 as key * 43 >> 9, exact for keys up to 127
    always_comb begin
        div_prod = 13'({6'd0, in_key} * 13'd43);
        cls_q    = div_prod[12:9];
        cls_rem  = in_key - 7'({cls_q, 3'b000} + {1'b0, cls_q, 2'b00});
        cls      = cls_rem[3:0];
        code_lo  = {cls, 2'b00} + {2'b00, cls};
        code     = i_cfg.class_offsets[code_lo +: 5];
        sum      = 9'(i_cfg.root_shift) + $signed({2'b00, in_key})
                 + $signed({4'b0000, code}) - 9'sd13;
        if (in_st[7:4] == MT_NOTE_ON && in_sec != 7'd0) begin
            kind = K_ON;
        end else if (in_st[7:4] == MT_NOTE_OFF || in_st[7:4] == MT_NOTE_ON) begin
            kind = K_OFF;
        end else if (in_st[7:4] == MT_POLY_PRESSURE) begin
            kind = K_PRESS;
        end else begin
            kind = K_PASS;
        end
    end

    always_comb begin
        fold = r_f_n;
        for (int i = 0; i < 7; i++) begin
            if (fold < 9'sd0) begin
                fold = fold + 9'sd12;
            end else if (fold > 9'sd127) begin
                fold = fold - 9'sd12;
            end
        end
    end

    always_comb begin
        out_of_range = (r_f_n < 9'sd0) || (r_f_n > 9'sd127);
        drop_shift   = out_of_range && !i_cfg.wrap_enable;
        np           = fold[6:0];
        in_ch        = r_f_st[3:0];

        if (i_cfg.forced_channel == 5'd0) begin
            tch = in_ch;
        end else if (i_cfg.forced_channel > 5'd16) begin
            tch = 4'd15;
        end else begin
            tch = 4'(i_cfg.forced_channel - 5'd1);
        end
        mch_none = (i_cfg.muted_channel == 5'd0);
        if (i_cfg.muted_channel > 5'd16) begin
            mch = 4'd15;
        end else begin
            mch = 4'(i_cfg.muted_channel - 5'd1);
        end

        o_item.op     = OP_PASS;
        o_item.addr   = {r_f_key, in_ch};
        o_item.status = r_f_st;
        o_item.key    = r_f_key;
        o_item.second = r_f_sec;
        o_item.wpitch = {1'b0, r_f_key};
        o_item.wchan  = in_ch;
        discard       = 1'b0;

        case (r_f_kind)
            K_ON: begin
                if (r_f_mute && !mch_none) begin
                    o_item.op     = OP_KEEP_PITCH;
                    o_item.status = {MT_NOTE_ON, mch};
                    o_item.wchan  = mch;
                end else if (r_f_mute || drop_shift) begin
                    o_item.op     = OP_SET_QUIET;
                    o_item.wpitch = {1'b1, r_f_key};
                end else begin
                    o_item.op     = OP_SET_EMIT;
                    o_item.status = {MT_NOTE_ON, tch};
                    o_item.key    = np;
                    o_item.wpitch = {1'b0, np};
                    o_item.wchan  = tch;
                end
            end
            K_OFF: begin
                o_item.op = OP_RELEASE;
            end
            K_PRESS: begin
                discard       = r_f_mute || drop_shift;
                o_item.status = {MT_POLY_PRESSURE, tch};
                o_item.key    = np;
            end
            default: ;
        endcase
    end

    assign o_push          = r_f_valid && !discard && !i_q_full;
    assign f_pop           = r_f_valid && (discard || !i_q_full);
    assign o_s_axis_tready = !i_hold && (!r_f_valid || f_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_f_valid <= i_s_axis_tvalid;
        end else if (f_pop) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_f_kind <= kind;
            r_f_st   <= in_st;
            r_f_key  <= in_key;
            r_f_sec  <= in_sec;
            r_f_mute <= (code == 5'd0);
            r_f_n    <= sum;
        end
    end

endmodule

/* src/msr_queue.sv */
// ----------------------------------------------------------------------------
// msr_queue: item queue between front and back
// Small circular buffer; DEPTH of at least 2.
// ----------------------------------------------------------------------------
module msr_queue
    import msr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* src/msr_back.sv */
// ----------------------------------------------------------------------------
// msr_back: sounding-note table and output register
// Read-modify-write of the note table, one item a cycle if output flows, with a
// write bypass for back-to-back hits; clears the table to identity after reset.
// ----------------------------------------------------------------------------
module msr_back
    import msr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_item              i_q_head,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata
);

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rd;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_b_valid;
    t_item             r_b_item;
    logic              r_byp_valid;
    logic [ADDR_W-1:0] r_byp_addr;
    t_entry            r_byp_data;
    logic              r_out_valid;
    logic [TDATA_W-1:0] r_out_data;

    t_entry            eff;
    logic              b_go;
    logic              emit;
    logic [7:0]        em_status;
    logic [KEY_W-1:0]  em_key;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    always_comb begin
        // a write in the cycle of the read is not in the read data: take it here
        eff = (r_byp_valid && r_byp_addr == r_b_item.addr) ? r_byp_data : r_rd;
        b_go  = r_b_valid && (!r_out_valid || i_m_axis_tready);
        o_pop = !i_q_empty && !r_clr_busy && (!r_b_valid || b_go);

        emit      = 1'b1;
        em_status = r_b_item.status;
        em_key    = r_b_item.key;
        wr_data.pitch = r_b_item.wpitch;
        wr_data.chan  = r_b_item.wchan;
        case (r_b_item.op)
            OP_SET_QUIET: begin
                emit = 1'b0;
            end
            OP_KEEP_PITCH: begin
                wr_data.pitch = eff.pitch;
            end
            OP_RELEASE: begin
                emit      = !eff.pitch[7];
                em_status = {MT_NOTE_OFF, eff.chan};
                em_key    = eff.pitch[6:0];
            end
            default: ;
        endcase

        if (r_clr_busy) begin
            wr_en         = 1'b1;
            wr_addr       = r_clr_addr;
            wr_data.pitch = {1'b0, r_clr_addr[ADDR_W-1:CH_W]};
            wr_data.chan  = r_clr_addr[CH_W-1:0];
        end else begin
            wr_en   = b_go && (r_b_item.op != OP_PASS);
            wr_addr = r_b_item.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // hold the corrected entry while the item waits
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[i_q_head.addr];
        end else begin
            r_rd <= eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_byp_valid <= wr_en;
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go) begin
                r_out_valid <= emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item <= i_q_head;
        end
        r_byp_addr <= wr_addr;
        r_byp_data <= wr_data;
        if (b_go && emit) begin
            r_out_data <= {2'b00, r_b_item.second, em_key, em_status};
        end
    end

    assign o_clearing      = r_clr_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* src/midi_scale_remapper.sv */
// ----------------------------------------------------------------------------
// midi_scale_remapper: MIDI note remapper with sounding-note table
// Shifts note-on and poly pressure by root and pitch-class offsets, and sends
// each note-off of a sent note with the pitch and channel it went out on.
// ----------------------------------------------------------------------------
// The block takes one word per clock and delivers one result word per clock
// when both sides keep flowing; a word passes through the front register, the
// queue, the table stage and the output register before its result is
// presented. The rate is set by the note table: one read-modify-write per
// word on a memory with one read and one write port, with a bypass for a
// word that hits the entry written just before. After reset the table is
// filled with identity entries, and no word is taken until it is full;
// configuration writes are taken at any time.
module midi_scale_remapper
    import msr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // status_byte [7:0], key_number [14:8], second_byte [21:15]
    input  logic [TDATA_W-1:0]     i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // out_status [7:0], out_key [14:8], out_second [21:15]
    output logic [TDATA_W-1:0]     o_m_axis_tdata
);

    t_cfg  cfg;
    logic  clearing;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item push_item;
    t_item head_item;

    msr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    msr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_hold          (clearing),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (push_item)
    );

    msr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_empty (q_empty)
    );

    msr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_head        (head_item),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
